// File: hw/rtl/lzbd_pkg.sv
// ----------------------------------------------------------------------------
// lzbd_pkg: shared types and constants for the LZ back-reference decoder
// Result kinds, decoder phases, window and counter widths, and the
// structs passed between the controller, the history window and the
// result queue.
// ----------------------------------------------------------------------------
package lzbd_pkg;

  localparam int WIN_DEPTH = 4096;
  localparam int WIN_AW    = $clog2(WIN_DEPTH);
  localparam int CNT_W     = 24;

  // offset field widths: short mode 12 bits, long mode 11 bits
  localparam int SHORT_SHIFT = 4;
  localparam int LONG_SHIFT  = 3;

  localparam logic [4:0] SHORT_LEN_MASK = 5'h0F;
  localparam logic [4:0] LONG_LEN_MASK  = 5'h1F;
  localparam logic [5:0] MATCH_LEN_BIAS = 6'd2;

  localparam logic [3:0] RAW_BLOCK_LEN = 4'd8;
  localparam logic [3:0] FLAGS_PER_CTRL = 4'd8;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  typedef enum logic [2:0] {
    PH_MODE,
    PH_CTRL,
    PH_RAW,
    PH_FLAG,
    PH_MLOW,
    PH_COPY,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } result_t;

  typedef struct packed {
    logic              wr_en;
    logic [WIN_AW-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [WIN_AW-1:0] rd_addr;
  } win_req_t;

endpackage

// File: hw/rtl/lzbd_window.sv
// ----------------------------------------------------------------------------
// lzbd_window: history window memory
// One write and one read per cycle, read data registered. A read of the
// entry written in the same cycle returns the new byte.
// ----------------------------------------------------------------------------
module lzbd_window (
  input  logic              clk,
  input  logic              rst_n,
  input  lzbd_pkg::win_req_t req,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [lzbd_pkg::WIN_DEPTH];
  logic [7:0] q_r;
  logic       fwd_r;
  logic       fwd_nxt;
  logic [7:0] fwd_data_r;

  assign fwd_nxt = req.wr_en && req.rd_en && (req.wr_addr == req.rd_addr);

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      q_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= req.wr_data;
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else begin
      fwd_r <= fwd_nxt;
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : q_r;

endmodule

// File: hw/rtl/lzbd_out_queue.sv
// ----------------------------------------------------------------------------
// lzbd_out_queue: two-entry result queue
// Registered output stage with one spare slot, so the decoder can push
// one more result while the receiver stalls.
// ----------------------------------------------------------------------------
module lzbd_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lzbd_pkg::result_t push_res,
  output logic [1:0]        count,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_byte,
  output logic              out_last
);

  lzbd_pkg::result_t ent_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        cnt_r;
  logic [1:0]        cnt_nxt;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign count     = cnt_r;
  assign out_kind  = ent_r[rd_ptr_r].kind;
  assign out_byte  = ent_r[rd_ptr_r].data;
  assign out_last  = ent_r[rd_ptr_r].last;

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_res;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hw/rtl/lzbd_ctrl.sv
// ----------------------------------------------------------------------------
// lzbd_ctrl: stream parser and copy sequencer
// Walks mode, control, raw, flag and match bytes, writes decoded bytes
// into the history window and runs back-reference copies one byte per
// cycle through the window's read port while the result queue has room.
// ----------------------------------------------------------------------------
module lzbd_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_byte,
  input  logic [lzbd_pkg::CNT_W-1:0] out_length,
  input  logic [1:0]                 q_count,
  input  logic                       q_pop,
  output logic                       push,
  output lzbd_pkg::result_t          push_res,
  output lzbd_pkg::win_req_t         win_req,
  input  logic [7:0]                 win_rd_data
);

  localparam int CW = lzbd_pkg::CNT_W;
  localparam int AW = lzbd_pkg::WIN_AW;

  lzbd_pkg::phase_t phase_r, phase_nxt;
  logic             long_r, long_nxt;
  logic [7:0]       flag_bits_r, flag_bits_nxt;
  logic [3:0]       flags_left_r, flags_left_nxt;
  logic [3:0]       raw_left_r, raw_left_nxt;
  logic [7:0]       hi_r, hi_nxt;
  logic [CW-1:0]    produced_r, produced_nxt;
  logic [AW-1:0]    wp_r, wp_nxt;
  logic [AW-1:0]    src_r, src_nxt;
  logic [5:0]       copy_left_r, copy_left_nxt;
  logic             rd_v_r, rd_v_nxt;
  logic             rd_last_r, rd_last_nxt;

  logic [CW:0]      room_diff;
  logic [CW-1:0]    room;
  logic             accept;
  logic [2:0]       occ;
  logic [3:0]       flags_dec;
  logic [3:0]       raw_dec;
  logic [5:0]       match_len;
  logic [AW-1:0]    offset;
  logic [4:0]       len_mask;

  assign room_diff = {1'b0, out_length} - {1'b0, produced_r};
  assign room      = room_diff[CW] ? '0 : room_diff[CW-1:0];

  assign in_ready = (phase_r != lzbd_pkg::PH_COPY) && !rd_v_r && (q_count != 2'd2);
  assign accept   = in_valid && in_ready;

  // slots taken in the queue once the byte now in flight has landed
  assign occ = {1'b0, q_count} + {2'b0, rd_v_r} - {2'b0, q_pop};

  assign flags_dec = (flags_left_r != 4'd0) ? flags_left_r - 4'd1 : 4'd0;
  assign raw_dec   = (raw_left_r != 4'd0) ? raw_left_r - 4'd1 : 4'd0;

  assign len_mask  = long_r ? lzbd_pkg::LONG_LEN_MASK : lzbd_pkg::SHORT_LEN_MASK;
  assign match_len = {1'b0, hi_r[4:0] & len_mask} + lzbd_pkg::MATCH_LEN_BIAS;
  assign offset    = long_r ? {1'b0, hi_r[7:5], in_byte} : {hi_r[7:4], in_byte};

  always_comb begin
    phase_nxt      = phase_r;
    long_nxt       = long_r;
    flag_bits_nxt  = flag_bits_r;
    flags_left_nxt = flags_left_r;
    raw_left_nxt   = raw_left_r;
    hi_nxt         = hi_r;
    produced_nxt   = produced_r;
    wp_nxt         = wp_r;
    src_nxt        = src_r;
    copy_left_nxt  = copy_left_r;
    rd_v_nxt       = 1'b0;
    rd_last_nxt    = rd_last_r;
    push           = 1'b0;
    push_res       = '0;
    win_req        = '0;
    win_req.wr_addr = wp_r;
    win_req.rd_addr = src_r;

    // copied byte arriving from the window
    if (rd_v_r) begin
      push           = 1'b1;
      push_res.kind  = lzbd_pkg::KIND_DATA;
      push_res.data  = win_rd_data;
      push_res.last  = rd_last_r;
      win_req.wr_en   = 1'b1;
      win_req.wr_data = win_rd_data;
      wp_nxt         = wp_r + 1'b1;
      produced_nxt   = produced_r + 1'b1;
    end

    if (phase_r == lzbd_pkg::PH_COPY && occ <= 3'd1) begin
      win_req.rd_en = 1'b1;
      src_nxt       = src_r + 1'b1;
      copy_left_nxt = copy_left_r - 6'd1;
      rd_v_nxt      = 1'b1;
      rd_last_nxt   = (copy_left_r == 6'd1);
      if (copy_left_r == 6'd1) begin
        flag_bits_nxt  = {flag_bits_r[6:0], 1'b0};
        flags_left_nxt = flags_dec;
        phase_nxt      = (flags_dec == 4'd0) ? lzbd_pkg::PH_CTRL : lzbd_pkg::PH_FLAG;
      end
    end

    if (accept) begin
      unique case (phase_r)
        lzbd_pkg::PH_MODE: begin
          long_nxt  = (in_byte != 8'd0);
          phase_nxt = lzbd_pkg::PH_CTRL;
        end
        lzbd_pkg::PH_CTRL: begin
          if (in_byte == 8'd0) begin
            if (room < CW'(lzbd_pkg::RAW_BLOCK_LEN)) begin
              push          = 1'b1;
              push_res.kind = lzbd_pkg::KIND_BAD;
              push_res.last = 1'b1;
              phase_nxt     = lzbd_pkg::PH_DONE;
            end else begin
              raw_left_nxt = lzbd_pkg::RAW_BLOCK_LEN;
              phase_nxt    = lzbd_pkg::PH_RAW;
            end
          end else begin
            flag_bits_nxt  = in_byte;
            flags_left_nxt = lzbd_pkg::FLAGS_PER_CTRL;
            phase_nxt      = lzbd_pkg::PH_FLAG;
          end
        end
        lzbd_pkg::PH_RAW: begin
          push            = 1'b1;
          push_res.kind   = lzbd_pkg::KIND_DATA;
          push_res.data   = in_byte;
          push_res.last   = 1'b1;
          win_req.wr_en   = 1'b1;
          win_req.wr_data = in_byte;
          wp_nxt          = wp_r + 1'b1;
          produced_nxt    = produced_r + 1'b1;
          raw_left_nxt    = raw_dec;
          if (raw_dec == 4'd0) begin
            phase_nxt = lzbd_pkg::PH_CTRL;
          end
        end
        lzbd_pkg::PH_FLAG: begin
          if (!flag_bits_r[7]) begin
            if (room == '0) begin
              push          = 1'b1;
              push_res.kind = lzbd_pkg::KIND_BAD;
              push_res.last = 1'b1;
              phase_nxt     = lzbd_pkg::PH_DONE;
            end else begin
              push            = 1'b1;
              push_res.kind   = lzbd_pkg::KIND_DATA;
              push_res.data   = in_byte;
              push_res.last   = 1'b1;
              win_req.wr_en   = 1'b1;
              win_req.wr_data = in_byte;
              wp_nxt          = wp_r + 1'b1;
              produced_nxt    = produced_r + 1'b1;
              flag_bits_nxt   = {flag_bits_r[6:0], 1'b0};
              flags_left_nxt  = flags_dec;
              if (flags_dec == 4'd0) begin
                phase_nxt = lzbd_pkg::PH_CTRL;
              end
            end
          end else if (in_byte == 8'd0) begin
            // end marker
            push          = 1'b1;
            push_res.kind = (produced_r == out_length) ? lzbd_pkg::KIND_OK
                                                       : lzbd_pkg::KIND_BAD;
            push_res.last = 1'b1;
            phase_nxt     = lzbd_pkg::PH_DONE;
          end else begin
            hi_nxt    = in_byte;
            phase_nxt = lzbd_pkg::PH_MLOW;
          end
        end
        lzbd_pkg::PH_MLOW: begin
          if (offset == '0 || CW'(offset) > produced_r || CW'(match_len) > room) begin
            push          = 1'b1;
            push_res.kind = lzbd_pkg::KIND_BAD;
            push_res.last = 1'b1;
            phase_nxt     = lzbd_pkg::PH_DONE;
          end else begin
            src_nxt       = wp_r - offset;
            copy_left_nxt = match_len;
            phase_nxt     = lzbd_pkg::PH_COPY;
          end
        end
        lzbd_pkg::PH_COPY: begin
        end
        lzbd_pkg::PH_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    hi_r        <= hi_nxt;
    src_r       <= src_nxt;
    rd_last_r   <= rd_last_nxt;
    if (!rst_n) begin
      phase_r      <= lzbd_pkg::PH_MODE;
      long_r       <= 1'b0;
      flag_bits_r  <= '0;
      flags_left_r <= '0;
      raw_left_r   <= '0;
      produced_r   <= '0;
      wp_r         <= '0;
      copy_left_r  <= '0;
      rd_v_r       <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      long_r       <= long_nxt;
      flag_bits_r  <= flag_bits_nxt;
      flags_left_r <= flags_left_nxt;
      raw_left_r   <= raw_left_nxt;
      produced_r   <= produced_nxt;
      wp_r         <= wp_nxt;
      copy_left_r  <= copy_left_nxt;
      rd_v_r       <= rd_v_nxt;
    end
  end

endmodule

// File: hw/rtl/lz_backref_byte_decoder_core.sv
// ----------------------------------------------------------------------------
// lz_backref_byte_decoder_core: LZSS decoder, 8-flag control bytes
// Top level: stream parser, 4096-byte history window and result queue.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : compressed bytes, one per transfer.
//   out_* : results; out_kind 0 is a data byte, 1 end ok, 2 corrupt stream.
//           out_last marks the final result caused by one input byte.
//   cfg_* : expected output length; always ready, write it while idle.
// Output path: a literal or an end result is registered in the result
//   queue before it shows on out_*. The bytes of a match pass the window
//   read register and the queue, one byte per cycle while the queue has room.
// Throughput: one mode, control, flag or literal byte per cycle while
//   in_ready is high; a match holds in_ready low until its copy has
//   passed the single read port of the window memory.
// Reset: clears the parser and counters; the window memory is not
//   cleared (no clearing pass) since it is read only where written.
// Stalls: a two-entry result queue holds results while out_ready is low;
//   in_ready drops while it is full, and a copy pauses as soon as the
//   queue plus the byte in flight would overfill it.
// After an end or corrupt result every further byte is taken and dropped.
// ----------------------------------------------------------------------------
module lz_backref_byte_decoder_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_kind,
  output logic [7:0]                 out_byte,
  output logic                       out_last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lzbd_pkg::CNT_W-1:0] cfg_data
);

  logic [lzbd_pkg::CNT_W-1:0] out_length_r;
  logic [1:0]                 q_count;
  logic                       q_pop;
  logic                       push;
  lzbd_pkg::result_t          push_res;
  lzbd_pkg::win_req_t         win_req;
  logic [7:0]                 win_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_length_r <= '0;
    end else if (cfg_valid) begin
      out_length_r <= cfg_data;
    end
  end

  lzbd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .out_length  (out_length_r),
    .q_count     (q_count),
    .q_pop       (q_pop),
    .push        (push),
    .push_res    (push_res),
    .win_req     (win_req),
    .win_rd_data (win_rd_data)
  );

  lzbd_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (win_req),
    .rd_data (win_rd_data)
  );

  lzbd_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_res  (push_res),
    .count     (q_count),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

// File: tb/lz_backref_byte_decoder_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz_backref_byte_decoder_core_test: stream-level check of the LZSS decoder
// Feeds one compressed stream: a directed opening with a raw block, literals
// and overlapping matches, then random well-formed flag groups under
// changing idle and stall mixes. It closes with one end case picked at
// random: clean end, short count, raw/literal/match overrun or a bad
// reference. A decoder model in the scoreboard predicts every result.
// ----------------------------------------------------------------------------

class lz_scoreboard;
  lzbd_pkg::phase_t                phase;
  bit                              long_mode;
  logic [7:0]                      flag_bits;
  int unsigned                     flags_left;
  int unsigned                     raw_left;
  logic [7:0]                      match_hi;
  logic [lzbd_pkg::CNT_W-1:0]      produced;
  logic [lzbd_pkg::CNT_W-1:0]      out_len;
  logic [7:0]                      history [lzbd_pkg::WIN_DEPTH];
  logic [lzbd_pkg::WIN_AW-1:0]     wr_ptr;
  lzbd_pkg::result_t               expected_q[$];
  lzbd_pkg::result_t               step_q[$];
  int                              errors;
  int                              checked;

  function new();
    phase      = lzbd_pkg::PH_MODE;
    long_mode  = 1'b0;
    flag_bits  = '0;
    flags_left = 0;
    raw_left   = 0;
    match_hi   = '0;
    produced   = '0;
    out_len    = '0;
    wr_ptr     = '0;
    errors     = 0;
    checked    = 0;
  endfunction

  function void set_length(logic [lzbd_pkg::CNT_W-1:0] v);
    out_len = v;
  endfunction

  function logic [lzbd_pkg::CNT_W-1:0] room();
    return (produced <= out_len) ? out_len - produced : '0;
  endfunction

  function void add(logic [1:0] kind, logic [7:0] b);
    lzbd_pkg::result_t r;
    r.kind = kind;
    r.data = b;
    r.last = 1'b0;
    step_q.push_back(r);
  endfunction

  function void emit(logic [7:0] b);
    history[wr_ptr] = b;
    wr_ptr = wr_ptr + 1'b1;
    produced = produced + 1'b1;
    add(lzbd_pkg::KIND_DATA, b);
  endfunction

  function void finish_stream(logic [1:0] kind);
    phase = lzbd_pkg::PH_DONE;
    add(kind, 8'h00);
  endfunction

  function void advance_flag();
    flag_bits = flag_bits << 1;
    if (flags_left > 0) flags_left--;
    if (flags_left == 0) phase = lzbd_pkg::PH_CTRL;
  endfunction

  // decode one accepted stream byte, queue what it produces
  function void note_input(logic [7:0] b);
    logic [lzbd_pkg::CNT_W-1:0]  space;
    int unsigned                 hi32;
    int unsigned                 len;
    int unsigned                 offset;
    logic [lzbd_pkg::WIN_AW-1:0] src;
    space = room();
    step_q.delete();
    case (phase)
      lzbd_pkg::PH_MODE: begin
        long_mode = (b != 8'h00);
        phase = lzbd_pkg::PH_CTRL;
      end
      lzbd_pkg::PH_CTRL: begin
        if (b == 8'h00) begin
          if (space < lzbd_pkg::RAW_BLOCK_LEN) finish_stream(lzbd_pkg::KIND_BAD);
          else begin
            raw_left = lzbd_pkg::RAW_BLOCK_LEN;
            phase = lzbd_pkg::PH_RAW;
          end
        end else begin
          flag_bits = b;
          flags_left = lzbd_pkg::FLAGS_PER_CTRL;
          phase = lzbd_pkg::PH_FLAG;
        end
      end
      lzbd_pkg::PH_RAW: begin
        emit(b);
        if (raw_left > 0) raw_left--;
        if (raw_left == 0) phase = lzbd_pkg::PH_CTRL;
      end
      lzbd_pkg::PH_FLAG: begin
        if (!flag_bits[7]) begin
          if (space == 0) finish_stream(lzbd_pkg::KIND_BAD);
          else begin
            emit(b);
            advance_flag();
          end
        end else if (b == 8'h00) begin
          finish_stream((produced == out_len) ? lzbd_pkg::KIND_OK : lzbd_pkg::KIND_BAD);
        end else begin
          match_hi = b;
          phase = lzbd_pkg::PH_MLOW;
        end
      end
      lzbd_pkg::PH_MLOW: begin
        hi32 = match_hi;
        len = (hi32 & (long_mode ? lzbd_pkg::LONG_LEN_MASK : lzbd_pkg::SHORT_LEN_MASK))
              + lzbd_pkg::MATCH_LEN_BIAS;
        offset = ((hi32 << (long_mode ? lzbd_pkg::LONG_SHIFT : lzbd_pkg::SHORT_SHIFT))
                  & 32'hFF00) | b;
        if (offset == 0 || offset > produced || len > space) begin
          finish_stream(lzbd_pkg::KIND_BAD);
        end else begin
          // forward copy, may read bytes written earlier in the same copy
          for (int i = 0; i < len; i++) begin
            src = wr_ptr - offset[lzbd_pkg::WIN_AW-1:0];
            emit(history[src]);
          end
          phase = lzbd_pkg::PH_FLAG;
          advance_flag();
        end
      end
      default: ;
    endcase
    if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
    foreach (step_q[i]) expected_q.push_back(step_q[i]);
  endfunction

  function void check_result(logic [1:0] kind, logic [7:0] b, logic last);
    lzbd_pkg::result_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result kind %0d byte %02h last %0b", $time, kind, b, last);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    checked++;
    if (want.kind !== kind) begin
      $display("%0t: kind expected %0d got %0d", $time, want.kind, kind);
      errors++;
    end
    if (want.data !== b) begin
      $display("%0t: out_byte expected %02h got %02h", $time, want.data, b);
      errors++;
    end
    if (want.last !== last) begin
      $display("%0t: out_last expected %0b got %0b", $time, want.last, last);
      errors++;
    end
  endfunction
endclass

module lz_backref_byte_decoder_core_test;

  localparam int CW             = lzbd_pkg::CNT_W;
  localparam int CYCLE_LIMIT    = 500000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int ITEMS_PER_MIX  = 45;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_ready;
  logic [7:0]    in_byte   = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [1:0]    out_kind;
  logic [7:0]    out_byte;
  logic          out_last;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [CW-1:0] cfg_data  = '0;

  lz_scoreboard sb;
  int         send_idle_pct = 0;
  int         stall_pct     = 0;
  int         hold_trigger  = 0;
  int         hold_seen     = 0;
  int         hold_left     = 0;
  int         cycles        = 0;
  int         bytes_sent    = 0;
  int         ending        = 0;
  logic [7:0] pending_lo    = '0;
  string      ending_names [6] = '{"clean end", "end with short count", "raw block overrun",
                                   "literal overrun", "match overrun", "bad reference"};

  lz_backref_byte_decoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: check transfers, random stalls, long hold-off on request
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_kind, out_byte, out_last);
    if (hold_seen != hold_trigger) begin
      hold_seen = hold_trigger;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles,
             sb.expected_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (sb.phase != lzbd_pkg::PH_DONE) bytes_sent++;
    sb.note_input(b);
  endtask

  task wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    // covers bytes that produce nothing yet still keep the parser busy
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_length(input logic [CW-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_length(v);
    cfg_valid <= 1'b0;
  endtask

  function logic [7:0] make_hi(logic [15:0] off, logic [4:0] lenf);
    if (sb.long_mode) return {off[10:8], lenf};
    else return {off[11:8], lenf[3:0]};
  endfunction

  task send_match(input logic [15:0] off, input logic [4:0] lenf);
    send_byte(make_hi(off, lenf));
    send_byte(off[7:0]);
  endtask

  // next well-formed byte for wherever the decoder currently stands
  function logic [7:0] pick_next();
    int unsigned max_off;
    logic [15:0] off;
    logic [4:0]  lenf;
    logic [7:0]  hi;
    case (sb.phase)
      lzbd_pkg::PH_CTRL: begin
        if (sb.produced == 0 || $urandom_range(0, 3) == 0) return 8'h00;
        return 8'($urandom_range(1, 255));
      end
      lzbd_pkg::PH_FLAG: begin
        if (!sb.flag_bits[7]) return 8'($urandom_range(0, 255));
        max_off = sb.long_mode ? 2047 : 4095;
        if (sb.produced < max_off) max_off = sb.produced;
        if ($urandom_range(0, 3) == 0) off = 16'($urandom_range(1, (max_off < 4) ? max_off : 4));
        else off = 16'($urandom_range(1, max_off));
        lenf = 5'($urandom_range(0, ($urandom_range(0, 3) == 0) ?
                   (sb.long_mode ? lzbd_pkg::LONG_LEN_MASK : lzbd_pkg::SHORT_LEN_MASK) : 3));
        hi = make_hi(off, lenf);
        // a zero high byte would end the stream
        if (hi == 8'h00) hi = 8'h01;
        pending_lo = off[7:0];
        return hi;
      end
      lzbd_pkg::PH_MLOW: return pending_lo;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task end_stream();
    logic [7:0]    seq[$];
    logic [CW-1:0] now;
    logic [4:0]    mask;
    logic [4:0]    lenf;
    logic [15:0]   off;
    int unsigned   max_off;
    while (sb.phase != lzbd_pkg::PH_CTRL) send_byte(pick_next());
    ending = $urandom_range(0, 5);
    now = sb.produced;
    mask = sb.long_mode ? lzbd_pkg::LONG_LEN_MASK : lzbd_pkg::SHORT_LEN_MASK;
    case (ending)
      0, 1: begin
        write_length((ending == 0) ? now : CW'(now + $urandom_range(1, 1000)));
        seq.push_back(8'h80 | 8'($urandom_range(0, 127)));
        seq.push_back(8'h00);
      end
      2: begin
        write_length(CW'(now + $urandom_range(0, lzbd_pkg::RAW_BLOCK_LEN - 1)));
        seq.push_back(8'h00);
      end
      3: begin
        write_length(now);
        seq.push_back(8'($urandom_range(1, 127)));
        seq.push_back(8'($urandom_range(0, 255)));
      end
      4: begin
        write_length(CW'(now + $urandom_range(0, mask + lzbd_pkg::MATCH_LEN_BIAS - 1)));
        seq.push_back(8'h80 | 8'($urandom_range(0, 127)));
        seq.push_back(make_hi(16'd1, mask));
        seq.push_back(8'h01);
      end
      default: begin
        write_length('1);
        max_off = sb.long_mode ? 2047 : 4095;
        lenf = 5'($urandom_range(1, mask));
        // offset zero, or one step before the first decoded byte
        if ($urandom_range(0, 1) == 1 && now + 1 <= max_off) off = 16'(now + 1);
        else off = 16'd0;
        seq.push_back(8'h80 | 8'($urandom_range(0, 127)));
        seq.push_back(make_hi(off, lenf));
        seq.push_back(off[7:0]);
      end
    endcase
    foreach (seq[i]) send_byte(seq[i]);
    // decoder is finished now; these are taken and dropped
    repeat (3) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int idle_tab [4]  = '{0, 64, 0, 9};
    int stall_tab [4] = '{0, 0, 64, 9};
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_length('0);
    write_length('1);

    // mode byte picks the offset split for the whole stream
    send_byte(($urandom_range(0, 1) == 1) ? 8'($urandom_range(1, 255)) : 8'h00);
    send_byte(8'h00);
    send_byte(8'h00); send_byte(8'hFF); send_byte(8'h80); send_byte(8'h01);
    send_byte(8'h55); send_byte(8'hAA); send_byte(8'h7F); send_byte(8'hFE);
    // flags alternate literal / match
    send_byte(8'h55);
    send_byte(8'hFF);
    send_match(16'd1, sb.long_mode ? lzbd_pkg::LONG_LEN_MASK : lzbd_pkg::SHORT_LEN_MASK);
    send_byte(8'h00);
    send_match(16'(sb.produced), 5'd1);
    send_byte(8'h5A);
    send_match(16'd2, 5'd2);
    send_byte(8'hA5);
    send_match(16'd5, 5'd3);

    for (int mix = 0; mix < 4; mix++) begin
      send_idle_pct = idle_tab[mix];
      stall_pct = stall_tab[mix];
      for (int n = 0; n < ITEMS_PER_MIX; n++) begin
        if (mix == 0 && n == 5) hold_trigger++;
        send_byte(pick_next());
      end
      write_length((mix == 1) ? '1 : CW'(sb.produced + $urandom_range(20000, 1000000)));
    end

    send_idle_pct = 20;
    stall_pct = 20;
    end_stream();
    wait_drained();

    $display("decoded %0d bytes from %0d stream bytes, %0d results checked, %s offsets",
             sb.produced, bytes_sent, sb.checked, sb.long_mode ? "11-bit" : "12-bit");
    $display("idle mixes none/sender/receiver/both, one long output hold-off, ending: %s",
             ending_names[ending]);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
